@@ rtl/dbscan_pkg.sv @@
// Shared types and constants for the DBSCAN point clustering block.
`default_nettype none
package dbscan_pkg;

  localparam int LBL_W  = 7;
  localparam int PIDX_W = 6;
  localparam int CID_W  = 6;
  localparam int CTOT_W = 7;
  localparam int EPS_W  = 32;
  localparam int MINN_W = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [LBL_W-1:0] LBL_UNCL  = 7'h7F;
  localparam logic [LBL_W-1:0] LBL_NOISE = 7'h7E;

  localparam logic [CFG_IDX_W-1:0] CFG_EPS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINN = 1'b1;

  // sweep modes
  localparam logic [1:0] SW_CNT  = 2'd0;  // count neighbors
  localparam logic [1:0] SW_SEED = 2'd1;  // enqueue all neighbors
  localparam logic [1:0] SW_GROW = 2'd2;  // enqueue unqueued unclassified neighbors

  typedef struct packed {
    logic       load;
    logic       run_init;
    logic       rd_ord;
    logic       rd_head;
    logic       ctr_seed;
    logic       lat_ctr;
    logic       sw_go;
    logic [1:0] sw_mode;
    logic       wr_noise;
    logic       wr_id;
    logic       open_q;
    logic       next_ord;
    logic       next_clus;
    logic       out_init;
    logic       emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic sw_done;
    logic is_core;
    logic lbl_uncl;
    logic lbl_noise;
    logic ord_end;
    logic q_empty;
    logic out_last;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/dbscan_ctrl.sv @@
// Sequencer for loading, cluster growth and result readout.
`default_nettype none
module dbscan_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire                   last_point_i,
  input  dbscan_pkg::dp_sts_t   sts_i,
  output dbscan_pkg::ctl_cmd_t  cmd_o,
  output logic                  busy_o
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_OTEST = 4'd1;
  localparam logic [3:0] S_ORD   = 4'd2;
  localparam logic [3:0] S_OCHK  = 4'd3;
  localparam logic [3:0] S_OSWP  = 4'd4;
  localparam logic [3:0] S_OSEED = 4'd5;
  localparam logic [3:0] S_QTEST = 4'd6;
  localparam logic [3:0] S_QWAIT = 4'd7;
  localparam logic [3:0] S_QCHK  = 4'd8;
  localparam logic [3:0] S_QSWP  = 4'd9;
  localparam logic [3:0] S_QGRW  = 4'd10;
  localparam logic [3:0] S_RRD   = 4'd11;
  localparam logic [3:0] S_REM   = 4'd12;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_LOAD);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_point_i) begin
            cmd_o.run_init = 1'b1;
            state_d = S_OTEST;
          end
        end
      end
      S_OTEST: begin
        if (sts_i.ord_end) begin
          cmd_o.out_init = 1'b1;
          state_d = S_RRD;
        end else begin
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        cmd_o.rd_ord = 1'b1;
        state_d = S_OCHK;
      end
      S_OCHK: begin
        if (!sts_i.lbl_uncl) begin
          cmd_o.next_ord = 1'b1;
          state_d = S_OTEST;
        end else begin
          cmd_o.lat_ctr = 1'b1;
          cmd_o.sw_go   = 1'b1;
          cmd_o.sw_mode = dbscan_pkg::SW_CNT;
          state_d = S_OSWP;
        end
      end
      S_OSWP: begin
        if (sts_i.sw_done) begin
          if (sts_i.is_core) begin
            cmd_o.open_q  = 1'b1;
            cmd_o.sw_go   = 1'b1;
            cmd_o.sw_mode = dbscan_pkg::SW_SEED;
            state_d = S_OSEED;
          end else begin
            cmd_o.wr_noise = 1'b1;
            cmd_o.next_ord = 1'b1;
            state_d = S_OTEST;
          end
        end
      end
      S_OSEED: begin
        if (sts_i.sw_done) begin
          state_d = S_QTEST;
        end
      end
      S_QTEST: begin
        if (sts_i.q_empty) begin
          cmd_o.next_clus = 1'b1;
          state_d = S_OTEST;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d = S_QWAIT;
        end
      end
      S_QWAIT: begin
        cmd_o.ctr_seed = 1'b1;
        state_d = S_QCHK;
      end
      S_QCHK: begin
        if (sts_i.lbl_noise) begin
          cmd_o.wr_id = 1'b1;
          state_d = S_QTEST;
        end else if (!sts_i.lbl_uncl) begin
          state_d = S_QTEST;
        end else begin
          cmd_o.wr_id   = 1'b1;
          cmd_o.lat_ctr = 1'b1;
          cmd_o.sw_go   = 1'b1;
          cmd_o.sw_mode = dbscan_pkg::SW_CNT;
          state_d = S_QSWP;
        end
      end
      S_QSWP: begin
        if (sts_i.sw_done) begin
          if (sts_i.is_core) begin
            cmd_o.sw_go   = 1'b1;
            cmd_o.sw_mode = dbscan_pkg::SW_GROW;
            state_d = S_QGRW;
          end else begin
            state_d = S_QTEST;
          end
        end
      end
      S_QGRW: begin
        if (sts_i.sw_done) begin
          state_d = S_QTEST;
        end
      end
      S_RRD: begin
        cmd_o.rd_ord = 1'b1;
        state_d = S_REM;
      end
      S_REM: begin
        cmd_o.emit     = 1'b1;
        state_d = sts_i.out_last ? S_LOAD : S_RRD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/dbscan_dp.sv @@
// Point, label and seed stores, neighbor sweep pipeline and result register.
`default_nettype none
module dbscan_dp #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  dbscan_pkg::ctl_cmd_t                  cmd_i,
  output dbscan_pkg::dp_sts_t                   sts_o,
  input  wire signed [COORD_BITS-1:0]           x_coord_i,
  input  wire signed [COORD_BITS-1:0]           y_coord_i,
  input  wire                                   cfg_we_i,
  input  wire [dbscan_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire [dbscan_pkg::EPS_W-1:0]           cfg_wdata_i,
  output logic                                  result_valid_o,
  output logic [dbscan_pkg::PIDX_W-1:0]         point_index_o,
  output logic [dbscan_pkg::CID_W-1:0]          clus_num_o,
  output logic                                  is_noise_o,
  output logic [dbscan_pkg::CTOT_W-1:0]         cluster_total_o,
  output logic                                  overflow_o,
  output logic                                  last_result_o
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 2 * COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int QW = 2 * COORD_BITS;
  localparam int SW = (QW + 1 > dbscan_pkg::EPS_W + 1) ? QW + 1 : dbscan_pkg::EPS_W + 1;
  localparam int LW = dbscan_pkg::LBL_W;

  logic [dbscan_pkg::EPS_W-1:0]  eps_q;
  logic [dbscan_pkg::MINN_W-1:0] minn_q;
  logic [CW-1:0]          cnt_q, ord_q, head_q, tail_q, sw_addr_q, ncnt_q;
  logic                   ovf_q;
  logic [dbscan_pkg::CTOT_W-1:0] clus_q;
  logic [IW-1:0]          ctr_q, i1_q, i2_q, q_rd_q;
  logic [MAX_POINTS-1:0]  lbl_v_q, qd_q;
  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic                   sw_act_q, v1_q, v2_q, lbl_vrd_q;
  logic [1:0]             sw_mode_q;
  logic [LW-1:0]          l2_q, lbl_rd_q;
  logic [QW-1:0]          sx_q, sy_q;
  logic [PW-1:0]          pt_rd_q;

  logic [PW-1:0] pt_mem  [MAX_POINTS];
  logic [LW-1:0] lbl_mem [MAX_POINTS];
  logic [IW-1:0] q_mem   [MAX_POINTS];

  logic                  issue, rd_en, hit, enq, cnt_hit, lbl_we, full;
  logic [IW-1:0]         rd_addr;
  logic [LW-1:0]         lbl_eff, lbl_wdata;
  logic signed [COORD_BITS-1:0] px, py;
  logic signed [DW-1:0]  dx, dy;
  logic [COORD_BITS-1:0] adx, ady;
  logic [SW-1:0]         dsum;

  // address selection for the shared read ports
  assign issue = sw_act_q && (sw_addr_q != cnt_q);
  assign rd_en = cmd_i.rd_ord || cmd_i.ctr_seed || issue;
  always_comb begin
    if (cmd_i.rd_ord) begin
      rd_addr = ord_q[IW-1:0];
    end else if (cmd_i.ctr_seed) begin
      rd_addr = q_rd_q;
    end else begin
      rd_addr = sw_addr_q[IW-1:0];
    end
  end

  assign lbl_eff = lbl_vrd_q ? lbl_rd_q : dbscan_pkg::LBL_UNCL;
  assign lbl_we  = cmd_i.wr_noise || cmd_i.wr_id || cmd_i.open_q;
  assign lbl_wdata = cmd_i.wr_noise ? dbscan_pkg::LBL_NOISE : LW'(clus_q[dbscan_pkg::CID_W-1:0]);
  assign full = (cnt_q == CW'(MAX_POINTS));

  // distance stage
  assign px  = pt_rd_q[PW-1:COORD_BITS];
  assign py  = pt_rd_q[COORD_BITS-1:0];
  assign dx  = DW'(cx_q) - DW'(px);
  assign dy  = DW'(cy_q) - DW'(py);
  assign adx = COORD_BITS'(dx[DW-1] ? -dx : dx);
  assign ady = COORD_BITS'(dy[DW-1] ? -dy : dy);

  assign dsum    = SW'(sx_q) + SW'(sy_q);
  assign hit     = v2_q && (dsum <= SW'(eps_q)) && (i2_q != ctr_q);
  assign cnt_hit = hit && (sw_mode_q == dbscan_pkg::SW_CNT);
  assign enq     = hit && ((sw_mode_q == dbscan_pkg::SW_SEED) ||
                   ((sw_mode_q == dbscan_pkg::SW_GROW) && !qd_q[i2_q] &&
                    (l2_q == dbscan_pkg::LBL_UNCL)));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      pt_mem[cnt_q[IW-1:0]] <= {x_coord_i, y_coord_i};
    end
    if (lbl_we) begin
      lbl_mem[ctr_q] <= lbl_wdata;
    end
    if (enq) begin
      q_mem[tail_q[IW-1:0]] <= i2_q;
    end
    if (rd_en) begin
      pt_rd_q   <= pt_mem[rd_addr];
      lbl_rd_q  <= lbl_mem[rd_addr];
      lbl_vrd_q <= lbl_v_q[rd_addr];
    end
    if (cmd_i.rd_head) begin
      q_rd_q <= q_mem[head_q[IW-1:0]];
    end
    if (cmd_i.lat_ctr) begin
      cx_q <= px;
      cy_q <= py;
    end
    i1_q <= sw_addr_q[IW-1:0];
    i2_q <= i1_q;
    l2_q <= lbl_eff;
    sx_q <= QW'(adx * adx);
    sy_q <= QW'(ady * ady);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q     <= 32'd5898;
      minn_q    <= 7'd5;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      clus_q    <= '0;
      ord_q     <= '0;
      ctr_q     <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      lbl_v_q   <= '0;
      qd_q      <= '0;
      sw_act_q  <= 1'b0;
      sw_mode_q <= dbscan_pkg::SW_CNT;
      sw_addr_q <= '0;
      ncnt_q    <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      result_valid_o  <= 1'b0;
      point_index_o   <= '0;
      clus_num_o      <= '0;
      is_noise_o      <= 1'b0;
      cluster_total_o <= '0;
      overflow_o      <= 1'b0;
      last_result_o   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dbscan_pkg::CFG_EPS:  eps_q  <= cfg_wdata_i;
          dbscan_pkg::CFG_MINN: minn_q <= cfg_wdata_i[dbscan_pkg::MINN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.emit && sts_o.out_last) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
      if (cmd_i.run_init || cmd_i.out_init) begin
        ord_q <= '0;
      end else if (cmd_i.next_ord || cmd_i.next_clus || cmd_i.emit) begin
        ord_q <= ord_q + 1'b1;
      end
      if (cmd_i.run_init) begin
        clus_q <= '0;
      end else if (cmd_i.next_clus) begin
        clus_q <= clus_q + 1'b1;
      end
      if (cmd_i.rd_ord) begin
        ctr_q <= ord_q[IW-1:0];
      end else if (cmd_i.ctr_seed) begin
        ctr_q <= q_rd_q;
      end
      if (cmd_i.run_init) begin
        lbl_v_q <= '0;
      end else if (lbl_we) begin
        lbl_v_q[ctr_q] <= 1'b1;
      end
      if (cmd_i.open_q) begin
        qd_q   <= '0;
        head_q <= '0;
        tail_q <= '0;
      end else begin
        if (cmd_i.rd_head) begin
          head_q <= head_q + 1'b1;
        end
        if (enq) begin
          tail_q     <= tail_q + 1'b1;
          qd_q[i2_q] <= 1'b1;
        end
      end
      if (cmd_i.sw_go) begin
        sw_act_q  <= 1'b1;
        sw_mode_q <= cmd_i.sw_mode;
        sw_addr_q <= '0;
        ncnt_q    <= '0;
      end else begin
        if (issue) begin
          sw_addr_q <= sw_addr_q + 1'b1;
        end else begin
          sw_act_q <= 1'b0;
        end
        if (cnt_hit) begin
          ncnt_q <= ncnt_q + 1'b1;
        end
      end
      v1_q <= issue && !cmd_i.sw_go;
      v2_q <= v1_q;
      result_valid_o <= cmd_i.emit;
      if (cmd_i.emit) begin
        point_index_o   <= dbscan_pkg::PIDX_W'(ord_q[IW-1:0]);
        is_noise_o      <= (lbl_eff >= dbscan_pkg::LBL_NOISE);
        clus_num_o      <= (lbl_eff >= dbscan_pkg::LBL_NOISE) ? '0 :
                           lbl_eff[dbscan_pkg::CID_W-1:0];
        cluster_total_o <= clus_q;
        overflow_o      <= ovf_q;
        last_result_o   <= sts_o.out_last;
      end
    end
  end

  assign sts_o.sw_done   = !(sw_act_q || v1_q || v2_q);
  assign sts_o.is_core   = (8'(ncnt_q) >= 8'(minn_q));
  assign sts_o.lbl_uncl  = (lbl_eff == dbscan_pkg::LBL_UNCL);
  assign sts_o.lbl_noise = (lbl_eff == dbscan_pkg::LBL_NOISE);
  assign sts_o.ord_end   = (ord_q == cnt_q);
  assign sts_o.q_empty   = (head_q == tail_q);
  assign sts_o.out_last  = ((ord_q + 1'b1) == cnt_q);

  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("seed queue read past its tail");
  a_tail_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sts_o.q_empty |-> tail_q <= cnt_q) else $error("seed queue holds more entries than points");
  a_ncnt_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_act_q |-> ncnt_q <= cnt_q) else $error("neighbor count exceeds point count");
  a_no_read_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> !(cmd_i.rd_ord || cmd_i.ctr_seed)) else $error("read port clash with sweep");

endmodule
`default_nettype wire

@@ rtl/dbscan_point_clustering.sv @@
// Top level of the DBSCAN 2D point clustering block.
//
//  channel   | handshake              | beat content
//  ----------+------------------------+------------------------------------------
//  point in  | start_i & !busy_o      | x_coord_i, y_coord_i, last_point_i
//  result    | result_valid_o strobe  | point_index_o, clus_num_o, is_noise_o,
//            |                        | cluster_total_o, overflow_o, last_result_o
//  config    | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// Loading takes one point a cycle. The beat with last_point_i starts clustering:
// each neighbor sweep reads the point store once per stored point through the
// registered distance pipeline, and every point gets one count sweep and at most
// one enqueue sweep; the results then follow, one per stored point in load order.
// busy_o stays high from that beat until the last result strobe.
// Reset clears counters, labels valid bits and control; config returns to defaults.
// Results come out as one-cycle strobes; the receiver cannot stall them.
`default_nettype none
module dbscan_point_clustering #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  output logic                             busy_o,
  input  wire signed [COORD_BITS-1:0]      x_coord_i,
  input  wire signed [COORD_BITS-1:0]      y_coord_i,
  input  wire                              last_point_i,
  input  wire                              cfg_we_i,
  input  wire [dbscan_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [dbscan_pkg::EPS_W-1:0]      cfg_wdata_i,
  output logic                             result_valid_o,
  output logic [dbscan_pkg::PIDX_W-1:0]    point_index_o,
  output logic [dbscan_pkg::CID_W-1:0]     clus_num_o,
  output logic                             is_noise_o,
  output logic [dbscan_pkg::CTOT_W-1:0]    cluster_total_o,
  output logic                             overflow_o,
  output logic                             last_result_o
);

  dbscan_pkg::ctl_cmd_t cmd;
  dbscan_pkg::dp_sts_t  sts;

  dbscan_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .last_point_i (last_point_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy_o       (busy_o)
  );

  dbscan_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .x_coord_i       (x_coord_i),
    .y_coord_i       (y_coord_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .point_index_o   (point_index_o),
    .clus_num_o      (clus_num_o),
    .is_noise_o      (is_noise_o),
    .cluster_total_o (cluster_total_o),
    .overflow_o      (overflow_o),
    .last_result_o   (last_result_o)
  );

endmodule
`default_nettype wire

@@ verif/dbscan_point_clustering_test.sv @@
// Self-checking testbench for the DBSCAN point clustering block.
`default_nettype none
module dbscan_point_clustering_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 64;
  localparam int LIMIT = 1000000;

  typedef struct {
    bit                  is_cfg;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
    logic                last;
    logic [dbscan_pkg::CFG_IDX_W-1:0] idx;
    logic [dbscan_pkg::EPS_W-1:0]     data;
  } beat_t;

  typedef struct {
    logic [dbscan_pkg::PIDX_W-1:0] pidx;
    logic [dbscan_pkg::CID_W-1:0]  cid;
    logic                          noise;
    logic [dbscan_pkg::CTOT_W-1:0] total;
    logic                          ovf;
    logic                          last;
  } label_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [15:0] x_coord_i = '0;
  logic signed [15:0] y_coord_i = '0;
  logic last_point_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [dbscan_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [dbscan_pkg::EPS_W-1:0] cfg_wdata_i = '0;
  logic busy_o, result_valid_o, is_noise_o, overflow_o, last_result_o;
  logic [dbscan_pkg::PIDX_W-1:0] point_index_o;
  logic [dbscan_pkg::CID_W-1:0] clus_num_o;
  logic [dbscan_pkg::CTOT_W-1:0] cluster_total_o;

  dbscan_point_clustering u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .x_coord_i, .y_coord_i, .last_point_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .result_valid_o, .point_index_o,
    .clus_num_o, .is_noise_o, .cluster_total_o, .overflow_o, .last_result_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  beat_t  pending_beats[$];
  label_t label_q[$];
  int errors = 0, cycles = 0, quiet = 0, gap = 0;
  int sets_done = 0, results_seen = 0, clusters_seen = 0;
  bit took = 0, burst = 0;

  // clustering state mirrored from the block
  int signed pt_x[NPTS], pt_y[NPTS];
  int pt_cnt = 0;
  bit pt_ovf = 0;
  logic [31:0] eps_sq = 32'd5898;
  logic [6:0]  min_nb = 7'd5;
  logic [6:0]  lbl[NPTS];
  bit          queued[NPTS];

  function automatic bit near(int a, int b);
    longint dx, dy;
    longint unsigned sum;
    dx = pt_x[a] - pt_x[b];
    dy = pt_y[a] - pt_y[b];
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sum = dx * dx + dy * dy;
    return sum <= {32'd0, eps_sq};
  endfunction

  function automatic bit core(int p);
    int n = 0;
    for (int i = 0; i < pt_cnt; i++) if (i != p && near(p, i)) n++;
    return n >= min_nb;
  endfunction

  function automatic void grow(int seed, logic [6:0] id);
    int fifo[$];
    int p;
    foreach (queued[i]) queued[i] = 0;
    lbl[seed] = id;
    for (int i = 0; i < pt_cnt; i++)
      if (i != seed && near(seed, i)) begin
        fifo = {fifo, i};
        queued[i] = 1;
      end
    while (fifo.size() > 0) begin
      p = fifo.pop_front();
      if (lbl[p] == dbscan_pkg::LBL_NOISE) begin
        lbl[p] = id;
        continue;
      end
      if (lbl[p] != dbscan_pkg::LBL_UNCL) continue;
      lbl[p] = id;
      if (!core(p)) continue;
      for (int i = 0; i < pt_cnt; i++)
        if (i != p && !queued[i] && lbl[i] == dbscan_pkg::LBL_UNCL && near(p, i)) begin
          fifo = {fifo, i};
          queued[i] = 1;
        end
    end
  endfunction

  function automatic void take_point(beat_t b);
    int nclus = 0;
    label_t r;
    if (pt_cnt < NPTS) begin
      pt_x[pt_cnt] = b.x;
      pt_y[pt_cnt] = b.y;
      pt_cnt++;
    end else pt_ovf = 1;
    if (!b.last) return;
    for (int i = 0; i < pt_cnt; i++) lbl[i] = dbscan_pkg::LBL_UNCL;
    for (int i = 0; i < pt_cnt; i++) begin
      if (lbl[i] != dbscan_pkg::LBL_UNCL) continue;
      if (!core(i)) lbl[i] = dbscan_pkg::LBL_NOISE;
      else begin
        grow(i, 7'(nclus & 6'h3F));
        nclus++;
      end
    end
    for (int i = 0; i < pt_cnt; i++) begin
      r.pidx  = dbscan_pkg::PIDX_W'(i);
      r.noise = lbl[i] >= dbscan_pkg::LBL_NOISE;
      r.cid   = r.noise ? '0 : lbl[i][dbscan_pkg::CID_W-1:0];
      r.total = dbscan_pkg::CTOT_W'(nclus);
      r.ovf   = pt_ovf;
      r.last  = (i + 1 == pt_cnt);
      label_q = {label_q, r};
    end
    clusters_seen += nclus;
    sets_done++;
    pt_cnt = 0;
    pt_ovf = 0;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    took <= start_i & ~busy_o;
    quiet <= (busy_o || label_q.size() > 0) ? 0 : quiet + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin : drive
    logic start_n;
    logic we_n;
    beat_t b;
    start_n = start_i;
    we_n = 1'b0;
    if (rst_ni) begin
      if (start_i && took) begin
        take_point(pending_beats.pop_front());
        start_n = 0;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (!burst && $urandom_range(0, 15) == 0) burst = 1;
        else if (burst && $urandom_range(0, 15) == 0) burst = 0;
      end
      if (!start_n) begin
        if (gap > 0) gap--;
        else if (pending_beats.size() > 0) begin
          b = pending_beats[0];
          if (!b.is_cfg) begin
            start_n = 1;
            x_coord_i <= b.x;
            y_coord_i <= b.y;
            last_point_i <= b.last;
          end else if (quiet >= 8) begin
            void'(pending_beats.pop_front());
            we_n = 1'b1;
            cfg_idx_i <= b.idx;
            cfg_wdata_i <= b.data;
            if (b.idx == dbscan_pkg::CFG_EPS) eps_sq = b.data;
            else min_nb = b.data[6:0];
          end
        end
      end
      cfg_we_i <= we_n;
      start_i <= start_n;
    end
  end

  always @(posedge clk_i) begin : check
    label_t e;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (label_q.size() == 0) begin
        $error("result with nothing expected, point_index %0d", point_index_o);
        errors++;
      end else begin
        e = label_q.pop_front();
        if (point_index_o !== e.pidx) begin
          $error("point_index exp %0d got %0d", e.pidx, point_index_o); errors++;
        end
        if (clus_num_o !== e.cid) begin
          $error("clus_num exp %0d got %0d", e.cid, clus_num_o); errors++;
        end
        if (is_noise_o !== e.noise) begin
          $error("is_noise exp %0d got %0d", e.noise, is_noise_o); errors++;
        end
        if (cluster_total_o !== e.total) begin
          $error("cluster_total exp %0d got %0d", e.total, cluster_total_o); errors++;
        end
        if (overflow_o !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, overflow_o); errors++;
        end
        if (last_result_o !== e.last) begin
          $error("last_result exp %0d got %0d", e.last, last_result_o); errors++;
        end
      end
    end
  end

  int n_points = 0;

  task automatic add_pt(int x, int y, bit last);
    beat_t b;
    b.is_cfg = 0;
    b.x = 16'(x);
    b.y = 16'(y);
    b.last = last;
    b.idx = '0;
    b.data = '0;
    pending_beats = {pending_beats, b};
    n_points++;
  endtask

  task automatic add_cfg(logic [dbscan_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    beat_t b;
    b.is_cfg = 1;
    b.x = '0;
    b.y = '0;
    b.last = 0;
    b.idx = idx;
    b.data = data;
    pending_beats = {pending_beats, b};
  endtask

  task automatic add_set(int size, int spread);
    int cx[3], cy[3], k;
    for (int c = 0; c < 3; c++) begin
      cx[c] = $urandom_range(0, 60000) - 30000;
      cy[c] = $urandom_range(0, 60000) - 30000;
    end
    for (int i = 0; i < size; i++) begin
      k = $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0)
        add_pt($urandom_range(0, 65535), $urandom_range(0, 65535), i == size - 1);
      else
        add_pt(cx[k] + $urandom_range(0, 2 * spread) - spread,
               cy[k] + $urandom_range(0, 2 * spread) - spread, i == size - 1);
    end
  endtask

  initial begin
    // directed: default radius, one dense group plus an outlier
    for (int i = 0; i < 6; i++) add_pt(100 + 20 * i, -50 + 10 * i, 0);
    add_pt(20000, 20000, 1);
    add_pt(32767, -32768, 1);
    add_cfg(dbscan_pkg::CFG_EPS, 32'd0);
    add_cfg(dbscan_pkg::CFG_MINN, 7'd1);
    add_pt(0, 0, 0);
    add_pt(0, 0, 0);
    add_pt(-32768, 32767, 0);
    add_pt(-1, -1, 1);
    add_cfg(dbscan_pkg::CFG_EPS, 32'hFFFF_FFFF);
    add_cfg(dbscan_pkg::CFG_MINN, 7'd0);
    add_pt(-32768, -32768, 0);
    add_pt(32767, 32767, 0);
    add_pt(0, 0, 1);
    add_cfg(dbscan_pkg::CFG_MINN, 7'd127);
    add_pt(5, 5, 0);
    add_pt(-5, -5, 1);
    add_cfg(dbscan_pkg::CFG_MINN, 7'd64);
    add_pt(1, 2, 0);
    add_pt(3, 4, 1);
    // random sets with varied radius and density threshold
    while (n_points < 150) begin
      if ($urandom_range(0, 2) == 0) begin
        add_cfg(dbscan_pkg::CFG_EPS,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(100, 20000));
        add_cfg(dbscan_pkg::CFG_MINN, $urandom_range(1, 5));
      end
      if (n_points > 80 && n_points < 100) add_set(66, 80);
      else add_set($urandom_range(1, 12), 100);
    end
    @(posedge rst_ni);
    wait (pending_beats.size() == 0 && !start_i && label_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d points in %0d sets, %0d labels checked, %0d clusters predicted.",
             n_points, sets_done, results_seen, clusters_seen);
    if (errors == 0 && label_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
  end

endmodule
`default_nettype wire
